// ===== sv/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types and constants for the SHA-1 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] hash_t;

    localparam hash_t INIT_H = '{
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_BYTE = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [2:0] LAST_WORD = 3'd4;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       byte_en;
        logic [1:0] byte_pos;
        logic [7:0] byte_val;
        logic       step;
    } sched_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/sha1_schedule.sv =====
// ----------------------------------------------------------------------------
// sha1_schedule
// Packs bytes big-endian into a 16-word shift line and expands the message
// schedule one word per round; the current round word is always at tap 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_schedule (
    input  wire                   aclk,
    input  sha1_pkg::sched_ctrl_t ctrl,
    output sha1_pkg::word_t       w_cur
);

    sha1_pkg::word_t line_reg [16];
    sha1_pkg::word_t line_next [16];
    logic [23:0]     acc_reg;
    logic [23:0]     acc_next;
    sha1_pkg::word_t expand;

    always_comb begin
        expand = line_reg[13] ^ line_reg[8] ^ line_reg[2] ^ line_reg[0];
        expand = {expand[30:0], expand[31]};
        acc_next = acc_reg;
        for (int i = 0; i < 16; i++) begin
            line_next[i] = line_reg[i];
        end
        if (ctrl.byte_en) begin
            acc_next = {acc_reg[15:0], ctrl.byte_val};
            if (ctrl.byte_pos == 2'd3) begin
                for (int i = 0; i < 15; i++) begin
                    line_next[i] = line_reg[i + 1];
                end
                line_next[15] = {acc_reg, ctrl.byte_val};
            end
        end else if (ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                line_next[i] = line_reg[i + 1];
            end
            line_next[15] = expand;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        for (int i = 0; i < 16; i++) begin
            line_reg[i] <= line_next[i];
        end
    end

    assign w_cur = line_reg[0];

endmodule

`default_nettype wire

// ===== sv/sha1_round.sv =====
// ----------------------------------------------------------------------------
// sha1_round
// Working variables a..e and the shared round unit, one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_round (
    input  wire                   aclk,
    input  wire                   load,
    input  wire                   step,
    input  wire  [6:0]            round_idx,
    input  sha1_pkg::word_t       w_cur,
    input  sha1_pkg::hash_t       chain_in,
    output sha1_pkg::hash_t       vars
);

    sha1_pkg::hash_t vars_reg;
    sha1_pkg::hash_t vars_next;
    sha1_pkg::word_t f_val;
    sha1_pkg::word_t k_val;
    sha1_pkg::word_t t_val;
    sha1_pkg::word_t a_v, b_v, c_v, d_v, e_v;

    always_comb begin
        a_v = vars_reg[0];
        b_v = vars_reg[1];
        c_v = vars_reg[2];
        d_v = vars_reg[3];
        e_v = vars_reg[4];
        if (round_idx < 7'd20) begin
            f_val = (b_v & c_v) ^ (~b_v & d_v);
            k_val = sha1_pkg::K0;
        end else if (round_idx < 7'd40) begin
            f_val = b_v ^ c_v ^ d_v;
            k_val = sha1_pkg::K1;
        end else if (round_idx < 7'd60) begin
            f_val = (b_v & c_v) ^ (b_v & d_v) ^ (c_v & d_v);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = b_v ^ c_v ^ d_v;
            k_val = sha1_pkg::K3;
        end
        t_val = {a_v[26:0], a_v[31:27]} + f_val + e_v + k_val + w_cur;
        vars_next = vars_reg;
        if (load) begin
            vars_next = chain_in;
        end else if (step) begin
            vars_next[0] = t_val;
            vars_next[1] = a_v;
            vars_next[2] = {b_v[1:0], b_v[31:2]};
            vars_next[3] = c_v;
            vars_next[4] = d_v;
        end
    end

    always_ff @(posedge aclk) begin
        vars_reg <= vars_next;
    end

    assign vars = vars_reg;

endmodule

`default_nettype wire

// ===== sv/sha1_message_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_message_hasher
// Byte-serial SHA-1 hasher with one shared round unit.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): each request carries s_opcode and
// s_data_byte. An absorb request stores one byte; the request that
// completes a 64-byte block also starts a compression of 80 rounds plus
// an update of the chaining values, and s_ready stays low until both are
// done. A finish request pads the message one byte per cycle, adds the
// 64-bit bit length, and runs one or two compressions; the five digest
// words then leave on the result channel (m_valid/m_ready), h0 first,
// m_last_word set on h4. The round unit runs one round per cycle, and no
// new byte is taken while a block is being compressed.
// While the receiver stalls, the current word holds and no new request
// is taken. After the last word the block returns to its reset state and
// accepts the next message. Reset (aresetn low, synchronous) loads the
// initial hash values and clears the byte and block counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_hasher (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_opcode,
    input  wire  [7:0]  s_data_byte,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    sha1_pkg::state_t      state_reg, state_next;
    sha1_pkg::hash_t       chain_reg, chain_next;
    logic [5:0]            byte_idx_reg, byte_idx_next;
    logic [54:0]           blk_cnt_reg, blk_cnt_next;
    logic [6:0]            round_reg, round_next;
    logic [63:0]           len_reg, len_next;
    logic                  first_reg, first_next;
    logic                  len_mode_reg, len_mode_next;
    logic                  len_done_reg, len_done_next;
    logic                  fin_reg, fin_next;
    logic [2:0]            out_idx_reg, out_idx_next;
    sha1_pkg::sched_ctrl_t sched_ctrl;
    sha1_pkg::word_t       w_cur;
    sha1_pkg::hash_t       vars;
    logic                  load;

    sha1_schedule u_sched (
        .aclk  (aclk),
        .ctrl  (sched_ctrl),
        .w_cur (w_cur)
    );

    sha1_round u_round (
        .aclk      (aclk),
        .load      (load),
        .step      (sched_ctrl.step),
        .round_idx (round_reg),
        .w_cur     (w_cur),
        .chain_in  (chain_reg),
        .vars      (vars)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha1_pkg::ST_IDLE;
            chain_reg    <= sha1_pkg::INIT_H;
            byte_idx_reg <= '0;
            blk_cnt_reg  <= '0;
            round_reg    <= '0;
            first_reg    <= 1'b0;
            len_mode_reg <= 1'b0;
            len_done_reg <= 1'b0;
            fin_reg      <= 1'b0;
            out_idx_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            byte_idx_reg <= byte_idx_next;
            blk_cnt_reg  <= blk_cnt_next;
            round_reg    <= round_next;
            first_reg    <= first_next;
            len_mode_reg <= len_mode_next;
            len_done_reg <= len_done_next;
            fin_reg      <= fin_next;
            out_idx_reg  <= out_idx_next;
        end
        len_reg <= len_next;
    end

    always_comb begin
        state_next          = state_reg;
        chain_next          = chain_reg;
        byte_idx_next       = byte_idx_reg;
        blk_cnt_next        = blk_cnt_reg;
        round_next          = round_reg;
        len_next            = len_reg;
        first_next          = first_reg;
        len_mode_next       = len_mode_reg;
        len_done_next       = len_done_reg;
        fin_next            = fin_reg;
        out_idx_next        = out_idx_reg;
        sched_ctrl.byte_en  = 1'b0;
        sched_ctrl.byte_pos = byte_idx_reg[1:0];
        sched_ctrl.byte_val = s_data_byte;
        sched_ctrl.step     = 1'b0;
        load                = 1'b0;
        s_ready             = 1'b0;
        m_valid             = 1'b0;

        case (state_reg)
            sha1_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_opcode == sha1_pkg::OP_ABSORB) begin
                        sched_ctrl.byte_en = 1'b1;
                        byte_idx_next      = byte_idx_reg + 6'd1;
                        if (byte_idx_reg == sha1_pkg::LAST_BYTE) begin
                            blk_cnt_next = blk_cnt_reg + 55'd1;
                            load         = 1'b1;
                            fin_next     = 1'b0;
                            state_next   = sha1_pkg::ST_COMPRESS;
                        end
                    end else begin
                        len_next      = {blk_cnt_reg, byte_idx_reg, 3'b000};
                        first_next    = 1'b1;
                        len_mode_next = 1'b0;
                        len_done_next = 1'b0;
                        fin_next      = 1'b1;
                        state_next    = sha1_pkg::ST_PAD;
                    end
                end
            end
            sha1_pkg::ST_PAD: begin
                sched_ctrl.byte_en = 1'b1;
                byte_idx_next      = byte_idx_reg + 6'd1;
                if (first_reg) begin
                    sched_ctrl.byte_val = sha1_pkg::PAD_BYTE;
                    first_next          = 1'b0;
                end else if (len_mode_reg || byte_idx_reg == sha1_pkg::LEN_START) begin
                    sched_ctrl.byte_val = len_reg[63:56];
                    len_next            = {len_reg[55:0], 8'h00};
                    len_mode_next       = 1'b1;
                    if (byte_idx_reg == sha1_pkg::LAST_BYTE) begin
                        len_done_next = 1'b1;
                    end
                end else begin
                    sched_ctrl.byte_val = 8'h00;
                end
                if (byte_idx_reg == sha1_pkg::LAST_BYTE) begin
                    load       = 1'b1;
                    state_next = sha1_pkg::ST_COMPRESS;
                end
            end
            sha1_pkg::ST_COMPRESS: begin
                sched_ctrl.step = 1'b1;
                round_next      = round_reg + 7'd1;
                if (round_reg == sha1_pkg::LAST_ROUND) begin
                    round_next = '0;
                    state_next = sha1_pkg::ST_UPDATE;
                end
            end
            sha1_pkg::ST_UPDATE: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + vars[i];
                end
                if (!fin_reg) begin
                    state_next = sha1_pkg::ST_IDLE;
                end else if (len_done_reg) begin
                    state_next = sha1_pkg::ST_OUT;
                end else begin
                    state_next = sha1_pkg::ST_PAD;
                end
            end
            sha1_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == sha1_pkg::LAST_WORD) begin
                        out_idx_next  = '0;
                        chain_next    = sha1_pkg::INIT_H;
                        byte_idx_next = '0;
                        blk_cnt_next  = '0;
                        fin_next      = 1'b0;
                        len_mode_next = 1'b0;
                        len_done_next = 1'b0;
                        state_next    = sha1_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sha1_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_digest_word = chain_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == sha1_pkg::LAST_WORD);

endmodule

`default_nettype wire
